// File: rtl/midi_controller_state_table_core_macros.svh
// Assertion macros shared by the MIDI state table RTL.
// Users must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef MIDI_CONTROLLER_STATE_TABLE_CORE_MACROS_SVH
`define MIDI_CONTROLLER_STATE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mcst_pkg.sv
// Shared types, constants and helpers for the MIDI state table core.
// Used by every module in this folder; depends on nothing.
package mcst_pkg;

    // Table geometry.
    localparam int CHANNEL_COUNT = 16;
    localparam int KEY_COUNT     = 128;
    localparam int CH_W          = 4;
    localparam int KEY_W         = 7;
    localparam int VAL_W         = 7;
    localparam int ADDR_W        = 1 + CH_W + KEY_W;
    localparam int TABLE_DEPTH   = 1 << ADDR_W;
    localparam int CH_SLOTS      = 1 << CH_W;

    // Stream payload geometry.
    localparam int LANES       = 4;
    localparam int LANE_W      = 2;
    localparam int PARAM_W     = 8;
    localparam int WORD_W      = 24;
    localparam int LEVEL_W     = 32;
    localparam int IN_TDATA_W  = WORD_W + LANES * PARAM_W;
    localparam int OUT_TDATA_W = LANES * LEVEL_W;

    // Channel voice commands (upper nibble of the status byte).
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_CONTROL  = 4'hB;
    localparam logic [3:0] CMD_PROGRAM  = 4'hC;
    localparam logic [3:0] CMD_PRESSURE = 4'hD;
    localparam logic [3:0] CMD_BEND     = 4'hE;

    // Query modes.
    localparam logic [7:0] MODE_PRESSURE = 8'd1;
    localparam logic [7:0] MODE_PROGRAM  = 8'd2;
    localparam logic [7:0] MODE_NOTE     = 8'd3;
    localparam logic [7:0] MODE_CONTROL  = 8'd4;
    localparam logic [7:0] MODE_BEND     = 8'd5;

    // Register indexes on the configuration port.
    localparam logic REG_QUERY_MODE = 1'b0;
    localparam logic REG_LISTEN_CH  = 1'b1;

    // Table select bit on the memory address.
    localparam logic TBL_CONTROL = 1'b0;
    localparam logic TBL_NOTE    = 1'b1;

    // (2^32 - 1) = 127 * SCALE_MULT + 15.
    localparam logic [25:0] SCALE_MULT = 26'd33818640;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_OUT
    } t_state;

    // Write command for the per-channel registers.
    typedef struct packed {
        logic             prog_we;
        logic             press_we;
        logic             bend_we;
        logic [CH_W-1:0]  ch;
        logic [VAL_W-1:0] value;
    } t_chan_wr;

    // Clamp a data byte to the 7-bit MIDI range.
    function automatic logic [VAL_W-1:0] sat7(input logic [7:0] v);
        return v[7] ? {VAL_W{1'b1}} : v[VAL_W-1:0];
    endfunction

endpackage

// File: rtl/mcst_table_ram.sv
// Controller and note velocity tables in one synchronous RAM.
// One write and one registered read per cycle; uses mcst_pkg.
module mcst_table_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [mcst_pkg::ADDR_W-1:0] i_waddr,
    input  logic [mcst_pkg::VAL_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [mcst_pkg::ADDR_W-1:0] i_raddr,
    output logic [mcst_pkg::VAL_W-1:0]  o_rdata
);

    logic [mcst_pkg::VAL_W-1:0] r_mem [mcst_pkg::TABLE_DEPTH];
    logic [mcst_pkg::VAL_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mcst_chan_regs.sv
// Per-channel program, pressure and pitch-bend high byte registers.
// Written by decoded messages, read for one channel; uses mcst_pkg.
module mcst_chan_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mcst_pkg::t_chan_wr          i_wr,
    input  logic [mcst_pkg::CH_W-1:0]   i_rd_ch,
    output logic [mcst_pkg::VAL_W-1:0]  o_program,
    output logic [mcst_pkg::VAL_W-1:0]  o_pressure,
    output logic [mcst_pkg::VAL_W-1:0]  o_bend
);

    logic [mcst_pkg::VAL_W-1:0] r_program  [mcst_pkg::CH_SLOTS];
    logic [mcst_pkg::VAL_W-1:0] r_pressure [mcst_pkg::CH_SLOTS];
    logic [mcst_pkg::VAL_W-1:0] r_bend     [mcst_pkg::CH_SLOTS];

    // Small tables live in flops so reset clears them at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mcst_pkg::CH_SLOTS; i++) begin
                r_program[i]  <= '0;
                r_pressure[i] <= '0;
                r_bend[i]     <= '0;
            end
        end else begin
            if (i_wr.prog_we) begin
                r_program[i_wr.ch] <= i_wr.value;
            end
            if (i_wr.press_we) begin
                r_pressure[i_wr.ch] <= i_wr.value;
            end
            if (i_wr.bend_we) begin
                r_bend[i_wr.ch] <= i_wr.value;
            end
        end
    end

    assign o_program  = r_program[i_rd_ch];
    assign o_pressure = r_pressure[i_rd_ch];
    assign o_bend     = r_bend[i_rd_ch];

endmodule

// File: rtl/mcst_scale.sv
// Scales a 7-bit value to floor(v * (2^32 - 1) / 127).
// Uses SCALE_MULT from mcst_pkg; purely combinational.
module mcst_scale (
    input  logic [mcst_pkg::VAL_W-1:0]   i_value,
    output logic [mcst_pkg::LEVEL_W-1:0] o_level
);

    logic [10:0] w_x15;
    logic [10:0] w_sum;
    logic [3:0]  w_frac;
    logic [31:0] w_prod;

    // v * (2^32 - 1) / 127 = v * SCALE_MULT + floor(15 * v / 127).
    // For x below 127 * 128, floor(x / 127) = (x + (x >> 7) + 1) >> 7.
    always_comb begin
        w_x15  = {i_value, 4'b0000} - {4'b0000, i_value};
        w_sum  = w_x15 + {7'b0, w_x15[10:7]} + 11'd1;
        w_frac = w_sum[10:7];
        w_prod = 32'(i_value) * 32'(mcst_pkg::SCALE_MULT);
        o_level = w_prod + {28'd0, w_frac};
    end

endmodule

// File: rtl/midi_controller_state_table_core.sv
// Top level of the MIDI channel state table: stream ports, APB registers,
// sequencer and output register. Uses mcst_pkg, mcst_table_ram,
// mcst_chan_regs, mcst_scale and the assertion macros header.
//
//  Channel   | Direction | Handshake                       | Beat contents
//  ----------+-----------+---------------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready   | message or query item
//  m_axis    | out       | m_axis_tvalid / m_axis_tready   | four scaled levels
//  apb       | in        | psel / penable / pready         | query_mode, listen_channel
//
// A message beat is taken in ST_IDLE; its table write lands at the accept edge.
// A query beat holds the input through the accept cycle, one ST_READ per lane, ST_LAST
// for the last read data and ST_OUT, which loads the output register once m_axis allows.
// After reset a clearing pass writes zero to all 4096 RAM entries, one per
// cycle, with s_axis_tready low; configuration writes are taken meanwhile.
// While a beat waits on a stalled m_axis, the next finished query waits in ST_OUT.
`include "midi_controller_state_table_core_macros.svh"

module midi_controller_state_table_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: midi_word[23:0], param_a[31:24], param_b[39:32], param_c[47:40],
    //        param_d[55:48]
    input  logic [mcst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: action[0]
    input  logic                             s_axis_tuser,
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: level_a[31:0], level_b[63:32], level_c[95:64], level_d[127:96]
    output logic [mcst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    // Configuration registers.
    logic [7:0]                 r_query_mode;
    logic [mcst_pkg::CH_W-1:0]  r_listen_ch;
    logic                       w_cfg_wr;

    // Sequencer state.
    mcst_pkg::t_state                 r_state, n_state;
    logic [mcst_pkg::ADDR_W-1:0]      r_clr;
    logic [mcst_pkg::LANE_W-1:0]      r_lane;
    logic [mcst_pkg::LANES-1:0][mcst_pkg::PARAM_W-1:0] r_params;
    logic                             w_clr_busy;
    logic                             w_clr_run;
    logic                             w_st_read;
    logic                             w_st_last;

    // Read capture pipeline.
    logic                             r_cap_pend;
    logic [mcst_pkg::LANE_W-1:0]      r_cap_lane;
    logic                             r_cap_mem;
    logic [mcst_pkg::VAL_W-1:0]       r_cap_fixed;
    logic [mcst_pkg::LEVEL_W-1:0]     r_lvl [mcst_pkg::LANES];

    // Output stage.
    logic                             r_out_valid;
    logic [mcst_pkg::OUT_TDATA_W-1:0] r_out_data;

    // Input decode.
    logic                             w_in_acc;
    logic                             w_in_query;
    logic [mcst_pkg::WORD_W-1:0]      w_word;
    logic [3:0]                       w_cmd;
    logic [mcst_pkg::CH_W-1:0]        w_msg_ch;
    logic [7:0]                       w_d1;
    logic [7:0]                       w_d2;
    logic                             w_msg_acc;
    logic [mcst_pkg::CH_W-1:0]        w_q_ch;

    // Lane read decode.
    logic [mcst_pkg::PARAM_W-1:0]     w_sel;
    logic [mcst_pkg::PARAM_W-1:0]     w_sel_m1;
    logic                             w_issue;
    logic                             w_iss_mem;
    logic [mcst_pkg::VAL_W-1:0]       w_iss_fixed;
    logic                             w_out_load;

    // RAM and channel register connections.
    logic                             ram_we;
    logic [mcst_pkg::ADDR_W-1:0]      ram_waddr;
    logic [mcst_pkg::VAL_W-1:0]       ram_wdata;
    logic                             ram_re;
    logic [mcst_pkg::ADDR_W-1:0]      ram_raddr;
    logic [mcst_pkg::VAL_W-1:0]       ram_rdata;
    mcst_pkg::t_chan_wr               w_chan_wr;
    logic [mcst_pkg::VAL_W-1:0]       w_program;
    logic [mcst_pkg::VAL_W-1:0]       w_pressure;
    logic [mcst_pkg::VAL_W-1:0]       w_bend;
    logic [mcst_pkg::VAL_W-1:0]       w_cap_val;
    logic [mcst_pkg::LEVEL_W-1:0]     w_cap_level;

    // ------------------------------------------------------------------
    // Configuration port: always ready, one register per 32-bit word.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_mode <= '0;
            r_listen_ch  <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                mcst_pkg::REG_QUERY_MODE: r_query_mode <= pwdata[7:0];
                mcst_pkg::REG_LISTEN_CH:  r_listen_ch  <= pwdata[mcst_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mcst_pkg::REG_QUERY_MODE: prdata = {24'd0, r_query_mode};
            mcst_pkg::REG_LISTEN_CH:  prdata = {28'd0, r_listen_ch};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Message decode; the write happens at the accept edge.
    assign s_axis_tready = (r_state == mcst_pkg::ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_in_query    = w_in_acc && s_axis_tuser;
    assign w_word        = s_axis_tdata[mcst_pkg::WORD_W-1:0];
    assign w_cmd         = w_word[7:4];
    assign w_msg_ch      = w_word[3:0];
    assign w_d1          = w_word[15:8];
    assign w_d2          = w_word[23:16];
    assign w_msg_acc     = w_in_acc && !s_axis_tuser
                           && ({1'b0, w_msg_ch} < 5'(mcst_pkg::CHANNEL_COUNT));

    // Channel that queries read; out-of-range channels fall back to zero.
    assign w_q_ch = ({1'b0, r_listen_ch} < 5'(mcst_pkg::CHANNEL_COUNT))
                    ? r_listen_ch : '0;

    // State decodes used by the datapath and the checks.
    assign w_clr_busy = (r_state == mcst_pkg::ST_CLEAR);
    assign w_clr_run  = w_clr_busy && (r_clr != '1);
    assign w_st_read  = (r_state == mcst_pkg::ST_READ);
    assign w_st_last  = (r_state == mcst_pkg::ST_LAST);

    always_comb begin
        w_chan_wr          = '0;
        w_chan_wr.ch       = w_msg_ch;
        w_chan_wr.value    = mcst_pkg::sat7(w_d1);
        if (w_msg_acc) begin
            case (w_cmd)
                mcst_pkg::CMD_PROGRAM:  w_chan_wr.prog_we  = 1'b1;
                mcst_pkg::CMD_PRESSURE: w_chan_wr.press_we = 1'b1;
                mcst_pkg::CMD_BEND: begin
                    w_chan_wr.bend_we = 1'b1;
                    w_chan_wr.value   = mcst_pkg::sat7(w_d2);
                end
                default: ;
            endcase
        end
    end

    // RAM write port: clearing pass, then controller and note messages.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        if (w_clr_busy) begin
            ram_we = 1'b1;
        end else if (w_msg_acc) begin
            ram_waddr = {mcst_pkg::TBL_CONTROL, w_msg_ch, w_d1[mcst_pkg::KEY_W-1:0]};
            ram_wdata = mcst_pkg::sat7(w_d2);
            case (w_cmd)
                mcst_pkg::CMD_CONTROL: ram_we = 1'b1;
                mcst_pkg::CMD_NOTE_ON: begin
                    ram_we       = 1'b1;
                    ram_waddr[mcst_pkg::ADDR_W-1] = mcst_pkg::TBL_NOTE;
                end
                mcst_pkg::CMD_NOTE_OFF: begin
                    ram_we       = 1'b1;
                    ram_waddr[mcst_pkg::ADDR_W-1] = mcst_pkg::TBL_NOTE;
                    ram_wdata    = '0;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Lane read: address or fixed value for the current lane.
    assign w_sel    = r_params[r_lane];
    assign w_sel_m1 = w_sel - 8'd1;

    always_comb begin
        ram_raddr   = {mcst_pkg::TBL_CONTROL, w_q_ch, w_sel[mcst_pkg::KEY_W-1:0]};
        w_iss_mem   = 1'b0;
        w_iss_fixed = '0;
        case (r_query_mode)
            mcst_pkg::MODE_PRESSURE: w_iss_fixed = w_pressure;
            mcst_pkg::MODE_PROGRAM:  w_iss_fixed = w_program;
            mcst_pkg::MODE_BEND:     w_iss_fixed = w_bend;
            mcst_pkg::MODE_NOTE: begin
                w_iss_mem = 1'b1;
                ram_raddr[mcst_pkg::ADDR_W-1] = mcst_pkg::TBL_NOTE;
            end
            mcst_pkg::MODE_CONTROL:  w_iss_mem = 1'b1;
            default: begin
                // Grouped mode: group (p - 1) mod 4 picks four controllers.
                w_iss_mem = (w_sel != '0);
                ram_raddr = {mcst_pkg::TBL_CONTROL, w_q_ch, 3'b000,
                             w_sel_m1[1:0], r_lane};
            end
        endcase
    end

    assign ram_re = w_issue && w_iss_mem;

    // ------------------------------------------------------------------
    // Sequencer: next state and per-state controls.
    always_comb begin
        n_state    = r_state;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            mcst_pkg::ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = mcst_pkg::ST_IDLE;
                end
            end
            mcst_pkg::ST_IDLE: begin
                if (w_in_query) begin
                    n_state = mcst_pkg::ST_READ;
                end
            end
            mcst_pkg::ST_READ: begin
                w_issue = 1'b1;
                if (r_lane == mcst_pkg::LANE_W'(mcst_pkg::LANES - 1)) begin
                    n_state = mcst_pkg::ST_LAST;
                end
            end
            mcst_pkg::ST_LAST: begin
                n_state = mcst_pkg::ST_OUT;
            end
            mcst_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = mcst_pkg::ST_IDLE;
                end
            end
            default: n_state = mcst_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcst_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Clearing pass address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (w_clr_busy) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Query parameters and lane counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
        end else if (w_in_acc) begin
            r_lane <= '0;
        end else if (w_issue) begin
            r_lane <= r_lane + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_query) begin
            r_params <= s_axis_tdata[mcst_pkg::IN_TDATA_W-1:mcst_pkg::WORD_W];
        end
    end

    // Read data returns in the cycle after issue; tag it with its lane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_pend <= 1'b0;
        end else begin
            r_cap_pend <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_cap_lane  <= r_lane;
            r_cap_mem   <= w_iss_mem;
            r_cap_fixed <= w_iss_fixed;
        end
    end

    assign w_cap_val = r_cap_mem ? ram_rdata : r_cap_fixed;

    always_ff @(posedge i_clk) begin
        if (r_cap_pend) begin
            r_lvl[r_cap_lane] <= w_cap_level;
        end
    end

    // Output register parts the sequencer from the downstream stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {r_lvl[3], r_lvl[2], r_lvl[1], r_lvl[0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Submodules.
    mcst_table_ram u_table_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mcst_chan_regs u_chan_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_chan_wr),
        .i_rd_ch    (w_q_ch),
        .o_program  (w_program),
        .o_pressure (w_pressure),
        .o_bend     (w_bend)
    );

    mcst_scale u_scale (
        .i_value (w_cap_val),
        .o_level (w_cap_level)
    );

    // ------------------------------------------------------------------
    // Assertions.
    `MCST_ASSERT_IMP(a_ram_no_rw_clash, ram_we, !ram_re, "RAM written and read at once")
    `MCST_ASSERT_NXT(a_clear_steps, w_clr_run, w_clr_busy && r_clr == $past(r_clr) + 1'b1, "clear gap")
    `MCST_ASSERT_NXT(a_query_starts, w_in_query, w_st_read && r_lane == '0, "query skipped lane zero")
    `MCST_ASSERT_IMP(a_capture_window, r_cap_pend, w_st_read || w_st_last, "late read data")

endmodule

// File: tb/midi_controller_state_table_core_tb.sv
// Self-checking testbench for the MIDI channel state table core.
// Drives message and query beats, predicts the four scaled levels of each query
// and checks every output beat. Depends on mcst_pkg and the core RTL only.
module midi_controller_state_table_core_tb;
    import mcst_pkg::*;

    // Item kinds carried on s_axis_tuser.
    localparam logic ACT_MESSAGE = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;

    // Levels that can be read off directly: empty table and full scale.
    localparam logic [31:0] LVL_ZERO = 32'h0000_0000;
    localparam logic [31:0] LVL_FULL = 32'hFFFF_FFFF;

    // Grouped controller modes that are not one of the named ones.
    localparam logic [7:0] MODE_GROUP_LOW  = 8'd0;
    localparam logic [7:0] MODE_GROUP_NEXT = 8'd6;
    localparam logic [7:0] MODE_GROUP_HIGH = 8'hFF;

    localparam int DIRECTED_ROWS  = 27;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int SEGMENTS       = 10;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;

    // One lane per 32-bit slice, lane a in the lowest bits.
    typedef logic [LANES-1:0][LEVEL_W-1:0] level_set_t;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic [7:0]  mode;
        logic [3:0]  chan;
        logic        act;
        logic [23:0] word;
        logic [31:0] sel;      // {d, c, b, a}
        logic        known;    // expected levels typed in below
        logic [31:0] lit;      // the same level on all four lanes
    } stim_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: midi_word[23:0], param_a[31:24], param_b[39:32], param_c[47:40],
    //        param_d[55:48]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // tuser: action[0]
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: level_a[31:0], level_b[63:32], level_c[95:64], level_d[127:96]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Predictor state: per-channel tables and the register copies.
    logic [6:0] ctl_vals [CHANNEL_COUNT][KEY_COUNT];
    logic [6:0] note_vels [CHANNEL_COUNT][KEY_COUNT];
    logic [6:0] prog_nums [CHANNEL_COUNT];
    logic [6:0] press_vals [CHANNEL_COUNT];
    logic [6:0] bend_vals [CHANNEL_COUNT];
    logic [7:0] mode_q = MODE_GROUP_LOW;
    logic [3:0] chan_q = '0;

    level_set_t pending_levels [$];

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int mismatches = 0;
    int msgs_sent = 0;
    int queries_sent = 0;
    int levels_checked = 0;
    int cfg_writes = 0;

    midi_controller_state_table_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Clamp a data byte to the 7-bit MIDI range.
    function automatic logic [6:0] clamp7(input logic [7:0] v);
        return v[7] ? 7'h7F : v[6:0];
    endfunction

    // Map 0..127 onto the full 32-bit range, rounding down.
    function automatic logic [31:0] to_level(input logic [6:0] v);
        logic [63:0] prod;
        prod = 64'(v) * 64'hFFFF_FFFF;
        return 32'(prod / 64'd127);
    endfunction

    // Decode one MIDI word into the predictor tables.
    function automatic void apply_message(input logic [23:0] word);
        logic [3:0] ch;
        logic [7:0] d1;
        logic [7:0] d2;
        ch = word[3:0];
        d1 = word[15:8];
        d2 = word[23:16];
        if (int'(ch) < CHANNEL_COUNT) begin
            case (word[7:4])
                CMD_CONTROL:  ctl_vals[ch][d1[6:0]] = clamp7(d2);
                CMD_NOTE_ON:  note_vels[ch][d1[6:0]] = clamp7(d2);
                CMD_NOTE_OFF: note_vels[ch][d1[6:0]] = '0;
                CMD_PROGRAM:  prog_nums[ch] = clamp7(d1);
                CMD_PRESSURE: press_vals[ch] = clamp7(d1);
                CMD_BEND:     bend_vals[ch] = clamp7(d2);
                default: ;
            endcase
        end
    endfunction

    // Work out the four levels that a query with these selectors returns.
    function automatic level_set_t query_levels(input logic [31:0] sel);
        level_set_t lv;
        logic [3:0] ch;
        logic [7:0] p;
        logic [7:0] grp;
        logic [6:0] v;
        ch = (int'(chan_q) < CHANNEL_COUNT) ? chan_q : 4'd0;
        for (int n = 0; n < LANES; n++) begin
            p = sel[8*n +: 8];
            case (mode_q)
                MODE_PRESSURE: v = press_vals[ch];
                MODE_PROGRAM:  v = prog_nums[ch];
                MODE_NOTE:     v = note_vels[ch][p[6:0]];
                MODE_CONTROL:  v = ctl_vals[ch][p[6:0]];
                MODE_BEND:     v = bend_vals[ch];
                default: begin
                    // Grouped mode: a zero selector mutes the lane.
                    grp = p - 8'd1;
                    v = (p == 8'd0) ? 7'd0 : ctl_vals[ch][{grp[1:0], 2'(n)}];
                end
            endcase
            lv[n] = to_level(v);
        end
        return lv;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch %0s: expected %h, got %h", what, exp_v, got_v);
    endtask

    // Directed stimulus: selectors are written {d, c, b, a}.
    function automatic stim_row_t directed_row(input int idx);
        case (idx)
            // Fresh tables read as zero in grouped and controller modes.
            0:  return '{MODE_GROUP_LOW, 4'd0, ACT_QUERY, 24'h0, 32'h03020100, 1'b1, LVL_ZERO};
            1:  return '{MODE_CONTROL, 4'd0, ACT_QUERY, 24'h0, 32'hFF80007F, 1'b1, LVL_ZERO};
            // Highest controller, then an index that needs masking and a value that saturates.
            2:  return '{MODE_CONTROL, 4'd0, ACT_MESSAGE, 24'h7F7FB0, 32'h0, 1'b0, LVL_ZERO};
            3:  return '{MODE_CONTROL, 4'd0, ACT_MESSAGE, 24'hC880B0, 32'h0, 1'b0, LVL_ZERO};
            4:  return '{MODE_CONTROL, 4'd0, ACT_QUERY, 24'h0, 32'hFF80007F, 1'b1, LVL_FULL};
            5:  return '{MODE_CONTROL, 4'd0, ACT_MESSAGE, 24'h4005B0, 32'h0, 1'b0, LVL_ZERO};
            6:  return '{MODE_CONTROL, 4'd0, ACT_QUERY, 24'hFFFFFF, 32'h85050006, 1'b0, LVL_ZERO};
            // Note on and off on the top channel.
            7:  return '{MODE_NOTE, 4'd15, ACT_MESSAGE, 24'h643C9F, 32'h0, 1'b0, LVL_ZERO};
            8:  return '{MODE_NOTE, 4'd15, ACT_MESSAGE, 24'hFF7F9F, 32'h0, 1'b0, LVL_ZERO};
            9:  return '{MODE_NOTE, 4'd15, ACT_QUERY, 24'h0, 32'hFF00BC3C, 1'b0, LVL_ZERO};
            10: return '{MODE_NOTE, 4'd15, ACT_MESSAGE, 24'h55BC8F, 32'h0, 1'b0, LVL_ZERO};
            11: return '{MODE_NOTE, 4'd15, ACT_MESSAGE, 24'h007F8F, 32'h0, 1'b0, LVL_ZERO};
            12: return '{MODE_NOTE, 4'd15, ACT_QUERY, 24'h0, 32'hFF7FBC3C, 1'b1, LVL_ZERO};
            // Program change saturates to full scale.
            13: return '{MODE_PROGRAM, 4'd15, ACT_MESSAGE, 24'h00FFCF, 32'h0, 1'b0, LVL_ZERO};
            14: return '{MODE_PROGRAM, 4'd15, ACT_QUERY, 24'h0, 32'h12345678, 1'b1, LVL_FULL};
            15: return '{MODE_PRESSURE, 4'd15, ACT_MESSAGE, 24'h7F20DF, 32'h0, 1'b0, LVL_ZERO};
            16: return '{MODE_PRESSURE, 4'd15, ACT_QUERY, 24'h0, 32'hA5A5A5A5, 1'b0, LVL_ZERO};
            // Pitch bend keeps only the second data byte.
            17: return '{MODE_BEND, 4'd15, ACT_MESSAGE, 24'h407FEF, 32'h0, 1'b0, LVL_ZERO};
            18: return '{MODE_BEND, 4'd15, ACT_QUERY, 24'h0, 32'h00000000, 1'b0, LVL_ZERO};
            19: return '{MODE_BEND, 4'd15, ACT_MESSAGE, 24'hFF00EF, 32'h0, 1'b0, LVL_ZERO};
            // Data byte as status, poly pressure and a system message are ignored.
            20: return '{MODE_BEND, 4'd15, ACT_MESSAGE, 24'h00007F, 32'h0, 1'b0, LVL_ZERO};
            21: return '{MODE_BEND, 4'd15, ACT_MESSAGE, 24'h0000AF, 32'h0, 1'b0, LVL_ZERO};
            22: return '{MODE_BEND, 4'd15, ACT_MESSAGE, 24'h0000FF, 32'h0, 1'b0, LVL_ZERO};
            23: return '{MODE_BEND, 4'd15, ACT_QUERY, 24'h0, 32'h0, 1'b1, LVL_FULL};
            // Grouped controller mode, including the muting zero selector.
            24: return '{MODE_GROUP_NEXT, 4'd0, ACT_MESSAGE, 24'h7F0BB0, 32'h0, 1'b0, LVL_ZERO};
            25: return '{MODE_GROUP_NEXT, 4'd0, ACT_QUERY, 24'h0, 32'hFF050100, 1'b0, LVL_ZERO};
            default:
                return '{MODE_GROUP_HIGH, 4'd0, ACT_QUERY, 24'h0, 32'h04030201, 1'b0, LVL_ZERO};
        endcase
    endfunction

    // Present one beat, honoring the sender idle rate, and predict at accept.
    task automatic send_item(input logic act, input logic [IN_TDATA_W-1:0] payload,
                             input logic known, input logic [31:0] lit);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        if (act == ACT_QUERY) begin
            pending_levels.push_back(known ? {LANES{lit}} : query_levels(payload[55:24]));
            queries_sent++;
        end else begin
            apply_message(payload[23:0]);
            msgs_sent++;
        end
    endtask

    // Stop sending, wait for every expected beat, then let a message finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value)
            note_mismatch(idx == REG_QUERY_MODE ? "query_mode read" : "listen_channel read",
                          value, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_QUERY_MODE)
            mode_q = value[7:0];
        else
            chan_q = value[3:0];
        cfg_writes++;
    endtask

    // Random beat: mostly voice messages and queries aimed at live entries.
    task automatic random_item(output logic act, output logic [IN_TDATA_W-1:0] payload);
        int pick;
        logic [3:0] cmd;
        logic [3:0] ch;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [31:0] sel;
        logic [23:0] word;
        pick = $urandom_range(99);
        for (int n = 0; n < LANES; n++)
            sel[8*n +: 8] = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom);
        word = 24'($urandom);
        act = ACT_MESSAGE;
        if (pick < 45) begin
            act = ACT_QUERY;
        end else if (pick < 90) begin
            case ($urandom_range(5))
                0: cmd = CMD_NOTE_OFF;
                1: cmd = CMD_NOTE_ON;
                2: cmd = CMD_CONTROL;
                3: cmd = CMD_PROGRAM;
                4: cmd = CMD_PRESSURE;
                default: cmd = CMD_BEND;
            endcase
            ch = ($urandom_range(99) < 70) ? chan_q : 4'($urandom);
            d1 = ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
            d2 = 8'($urandom);
            word = {d2, d1, cmd, ch};
        end
        // Otherwise a raw word with any status, mostly ignored by the block.
        payload = {sel, word};
    endtask

    // Output side: check each accepted beat, then pick the next ready value.
    always @(posedge i_clk) begin
        level_set_t want;
        level_set_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = level_set_t'(m_axis_tdata);
            if (pending_levels.size() == 0) begin
                note_mismatch("unexpected beat, lane a", LVL_ZERO, got[0]);
            end else begin
                want = pending_levels.pop_front();
                for (int n = 0; n < LANES; n++) begin
                    if (got[n] !== want[n])
                        note_mismatch($sformatf("level lane %0d", n), want[n], got[n]);
                end
                levels_checked++;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // Main sequence: reset, directed table, then random segments.
    initial begin
        stim_row_t row;
        logic act;
        logic [IN_TDATA_W-1:0] payload;
        logic [7:0] seg_mode;
        logic [3:0] seg_chan;
        int done;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                ctl_vals[c][k] = '0;
                note_vels[c][k] = '0;
            end
            prog_nums[c] = '0;
            press_vals[c] = '0;
            bend_vals[c] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers are writable while the tables are still being cleared.
        write_reg(REG_QUERY_MODE, 32'(MODE_GROUP_LOW));
        write_reg(REG_LISTEN_CH, 32'd0);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_row(i);
            if (row.mode != mode_q || row.chan != chan_q) begin
                settle();
                if (row.mode != mode_q)
                    write_reg(REG_QUERY_MODE, 32'(row.mode));
                if (row.chan != chan_q)
                    write_reg(REG_LISTEN_CH, 32'(row.chan));
            end
            send_item(row.act, {row.sel, row.word}, row.known, row.lit);
        end

        for (int s = 0; s < SEGMENTS; s++) begin
            settle();
            case (s)
                0: seg_mode = MODE_CONTROL;
                1: seg_mode = MODE_NOTE;
                2: seg_mode = MODE_GROUP_LOW;
                3: seg_mode = MODE_PRESSURE;
                4: seg_mode = MODE_PROGRAM;
                5: seg_mode = MODE_BEND;
                6: seg_mode = MODE_GROUP_HIGH;
                7: seg_mode = 8'($urandom);
                8: seg_mode = MODE_NOTE;
                default: seg_mode = MODE_CONTROL;
            endcase
            seg_chan = (s == 0) ? 4'd0 : (s == 1) ? 4'd15 : 4'($urandom);
            write_reg(REG_QUERY_MODE, 32'(seg_mode));
            write_reg(REG_LISTEN_CH, 32'(seg_chan));
            // Idle pattern: none, sender, receiver, both lightly.
            case (s % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 83; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 83; end
                default: begin snd_idle_pct = 10; rcv_stall_pct = 10; end
            endcase
            done = 0;
            while (done < RANDOM_ITEMS / SEGMENTS) begin
                // Halfway through, hold off until the output has drained.
                if (done == RANDOM_ITEMS / SEGMENTS / 2)
                    settle();
                random_item(act, payload);
                send_item(act, payload, 1'b0, LVL_ZERO);
                done++;
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        $display("covered %0d message beats and %0d query beats, %0d level sets checked",
                 msgs_sent, queries_sent, levels_checked);
        $display("%0d register writes over all query modes; %0d mismatches",
                 cfg_writes, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/mcst_pkg.sv
rtl/mcst_table_ram.sv
rtl/mcst_chan_regs.sv
rtl/mcst_scale.sv
rtl/midi_controller_state_table_core.sv
tb/midi_controller_state_table_core_tb.sv
